/* hdl/gfba_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the free block allocator.
package gfba_pkg;

  localparam int unsigned NUM_BLOCKS_DEFAULT = 256;
  localparam int unsigned GROUP_SIZE_DEFAULT = 16;

  localparam int unsigned BLK_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USED_W   = 9;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [USED_W-1:0] USED_MAX = 9'd256;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_BLOCK = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP_READ,
    OP_POP_TAKE,
    OP_SPILL,
    OP_REFILL,
    OP_SPILL_END,
    OP_REFILL_END,
    OP_REJECT_EMPTY,
    OP_REJECT_BAD
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic blk_bad;
    logic leader_bad;
    logic count_gt1;
    logic stack_full;
    logic xfer_last;
  } dp_stat_t;

endpackage

/* hdl/grouped_free_block_allocator.sv */
// Top level of the grouped free block allocator: controller plus datapath.
//
// Hands out and takes back block numbers using a UNIX-style grouped free list.
// Each beat on the input asks either to allocate one block (func_i = 0) or to
// free block_number_i (func_i = 1), and produces exactly one result beat:
// the granted block (zero on a free or on failure), a status (ok, no free
// block left, or freed block number invalid) and the number of blocks in use
// after the operation, saturating at 0 and 256. The chain starts empty after
// reset; the host builds it by freeing blocks. One item is worked at a time.
// A plain push or a rejected request is decoded and then parked in the result
// register; a plain pop first reads the stack top. When a free finds the stack
// full, or an allocate reaches the last stack entry, GROUP_SIZE + 1 words move
// between the stack memory and the group memory one word per cycle. The input
// is ready again as soon as the result is parked in the output register, even
// while that result still waits to be taken. Allocating from a group that
// was never spilled returns an undefined block number.
module grouped_free_block_allocator import gfba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
  parameter int unsigned GROUP_SIZE = GROUP_SIZE_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic [BLK_W-1:0]    block_number_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BLK_W-1:0]    granted_block_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [USED_W-1:0]   used_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequence each beat: decode, then push/pop, a rejection or a full group transfer.
  gfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the free stack, the per-block group store and the used counter.
  gfba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .func_i          (func_i),
    .block_number_i  (block_number_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .granted_block_o (granted_block_o),
    .status_o        (status_o),
    .used_count_o    (used_count_o)
  );

endmodule

/* hdl/gfba_dp.sv */
// Datapath: free stack, group memory, counters and result registers.
module gfba_dp import gfba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
  parameter int unsigned GROUP_SIZE = GROUP_SIZE_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                func_i,
  input  logic [BLK_W-1:0]    block_number_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output logic [BLK_W-1:0]    granted_block_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [USED_W-1:0]   used_count_o
);

  localparam int unsigned GROUP_WORDS = GROUP_SIZE + 1;
  localparam int unsigned BLK_SPACE   = 1 << BLK_W;
  localparam int unsigned MEM_BLOCKS  = (NUM_BLOCKS < BLK_SPACE) ? NUM_BLOCKS : BLK_SPACE;
  localparam int unsigned MEM_DEPTH   = MEM_BLOCKS * GROUP_WORDS;
  localparam int unsigned ADDR_W      = $clog2(MEM_DEPTH);
  localparam int unsigned IDX_W       = $clog2(GROUP_WORDS);

  logic [BLK_W-1:0] stack_mem [GROUP_WORDS];
  logic [BLK_W-1:0] group_mem [MEM_DEPTH];

  logic                func_q;
  logic [BLK_W-1:0]    blk_q;
  logic [ADDR_W-1:0]   base_q;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [BLK_W-1:0]    leader_q, leader_d;
  logic [USED_W-1:0]   used_q, used_d;
  logic [IDX_W-1:0]    idx_q;
  logic                wr_v_q;
  logic                wr_refill_q;
  logic [IDX_W-1:0]    wr_idx_q;
  logic [BLK_W-1:0]    res_granted_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [BLK_W-1:0]    granted_q;
  logic [STATUS_W-1:0] status_q;
  logic [USED_W-1:0]   used_out_q;
  logic [BLK_W-1:0]    stack_rdata_q;
  logic [BLK_W-1:0]    group_rdata_q;

  logic [BLK_W-1:0]   blk_sel;
  logic [ADDR_W-1:0]  base_d;
  logic               issue;
  logic [IDX_W-1:0]   stack_raddr;
  logic [ADDR_W-1:0]  group_raddr;
  logic [ADDR_W-1:0]  group_waddr;
  logic [COUNT_W-1:0] count_inc;
  logic               stack_we;
  logic [IDX_W-1:0]   stack_waddr;
  logic [BLK_W-1:0]   stack_wdata;
  logic               group_we;
  logic [BLK_W-1:0]   group_wdata;
  logic [COUNT_W-1:0] refill_count;

  assign blk_sel = func_i ? block_number_i : leader_q;
  assign base_d  = ADDR_W'(ADDR_W'(blk_sel) * ADDR_W'(GROUP_WORDS));

  assign stat_o.is_free    = func_q;
  assign stat_o.blk_bad    = (blk_q == '0) || (32'(blk_q) >= NUM_BLOCKS);
  assign stat_o.leader_bad = (leader_q == '0) || (32'(leader_q) >= NUM_BLOCKS);
  assign stat_o.count_gt1  = count_q > COUNT_W'(1);
  assign stat_o.stack_full = count_q >= COUNT_W'(GROUP_SIZE);
  assign stat_o.xfer_last  = idx_q == IDX_W'(GROUP_SIZE);

  assign issue       = (cmd_i.op == OP_SPILL) || (cmd_i.op == OP_REFILL);
  assign stack_raddr = (cmd_i.op == OP_POP_READ) ? count_q[IDX_W-1:0] : idx_q;
  assign group_raddr = base_q + ADDR_W'(idx_q);
  assign group_waddr = base_q + ADDR_W'(wr_idx_q);
  assign count_inc   = count_q + COUNT_W'(1);

  // Clamp a stored group count into one..group size.
  always_comb begin
    if (group_rdata_q == '0) begin
      refill_count = COUNT_W'(1);
    end else if (group_rdata_q > BLK_W'(GROUP_SIZE)) begin
      refill_count = COUNT_W'(GROUP_SIZE);
    end else begin
      refill_count = group_rdata_q[COUNT_W-1:0];
    end
  end

  // Stack write port: push, or a refilled entry above the leader slot.
  always_comb begin
    stack_we    = 1'b0;
    stack_waddr = count_inc[IDX_W-1:0];
    stack_wdata = blk_q;
    if (cmd_i.op == OP_PUSH) begin
      stack_we = 1'b1;
    end else if (wr_v_q && wr_refill_q && (wr_idx_q > IDX_W'(1))) begin
      stack_we    = 1'b1;
      stack_waddr = wr_idx_q;
      stack_wdata = group_rdata_q;
    end
  end

  // Group write port: word zero holds the count, word one the leader slot.
  assign group_we = wr_v_q && !wr_refill_q;
  always_comb begin
    if (wr_idx_q == '0) begin
      group_wdata = BLK_W'(count_q);
    end else if (wr_idx_q == IDX_W'(1)) begin
      group_wdata = leader_q;
    end else begin
      group_wdata = stack_rdata_q;
    end
  end

  always_comb begin
    count_d  = count_q;
    leader_d = leader_q;
    used_d   = used_q;
    if (wr_v_q && wr_refill_q && (wr_idx_q == '0)) begin
      count_d = refill_count;
    end
    if (wr_v_q && wr_refill_q && (wr_idx_q == IDX_W'(1))) begin
      leader_d = group_rdata_q;
    end
    case (cmd_i.op)
      OP_PUSH: begin
        count_d = count_inc;
        if (used_q != '0) used_d = used_q - USED_W'(1);
      end
      OP_SPILL_END: begin
        count_d  = COUNT_W'(1);
        leader_d = blk_q;
        if (used_q != '0) used_d = used_q - USED_W'(1);
      end
      OP_POP_TAKE: begin
        count_d = count_q - COUNT_W'(1);
        if (used_q < USED_MAX) used_d = used_q + USED_W'(1);
      end
      OP_REFILL_END: begin
        if (used_q < USED_MAX) used_d = used_q + USED_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= COUNT_W'(1);
      leader_q    <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      wr_v_q      <= 1'b0;
      wr_refill_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      leader_q    <= leader_d;
      used_q      <= used_d;
      wr_v_q      <= issue;
      wr_refill_q <= (cmd_i.op == OP_REFILL);
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q <= idx_q;
    if (cmd_i.load) begin
      func_q        <= func_i;
      blk_q         <= block_number_i;
      base_q        <= base_d;
      res_granted_q <= leader_q;
      res_status_q  <= ST_OK;
    end
    case (cmd_i.op)
      OP_POP_TAKE:  res_granted_q <= stack_rdata_q;
      OP_PUSH,
      OP_SPILL_END: res_granted_q <= '0;
      OP_REJECT_EMPTY: begin
        res_granted_q <= '0;
        res_status_q  <= ST_NO_FREE;
      end
      OP_REJECT_BAD: begin
        res_granted_q <= '0;
        res_status_q  <= ST_BAD_BLOCK;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      granted_q  <= res_granted_q;
      status_q   <= res_status_q;
      used_out_q <= used_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (group_we) group_mem[group_waddr] <= group_wdata;
    group_rdata_q <= group_mem[group_raddr];
  end

  assign granted_block_o = granted_q;
  assign status_o        = status_q;
  assign used_count_o    = used_out_q;

endmodule

/* hdl/gfba_ctrl.sv */
// Controller: sequences push, pop, group spill and group refill over the datapath.
module gfba_ctrl import gfba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_XFER,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_free) begin
          if (stat_i.blk_bad) begin
            cmd_o.op = OP_REJECT_BAD;
            state_d  = S_FINISH;
          end else if (!stat_i.stack_full) begin
            cmd_o.op = OP_PUSH;
            state_d  = S_FINISH;
          end else begin
            state_d = S_XFER;
          end
        end else if (stat_i.count_gt1) begin
          cmd_o.op = OP_POP_READ;
          state_d  = S_POP;
        end else if (stat_i.leader_bad) begin
          cmd_o.op = OP_REJECT_EMPTY;
          state_d  = S_FINISH;
        end else begin
          state_d = S_XFER;
        end
      end
      S_POP: begin
        cmd_o.op = OP_POP_TAKE;
        state_d  = S_FINISH;
      end
      S_XFER: begin
        cmd_o.op = stat_i.is_free ? OP_SPILL : OP_REFILL;
        if (stat_i.xfer_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.op = stat_i.is_free ? OP_SPILL_END : OP_REFILL_END;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/gfba_checker.sv */
// Port-level checks on the allocator, bound to the top level.
module gfba_checker import gfba_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                func_i,
  input logic [BLK_W-1:0]    block_number_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [BLK_W-1:0]    granted_block_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [USED_W-1:0]   used_count_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_block_o)
      && $stable(status_o) && $stable(used_count_o))
    else $error("result beat changed while stalled");

  // One item at a time: the input closes right after a beat is taken.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  // Only defined status codes, and the used count stays in range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_NO_FREE
      || status_o == ST_BAD_BLOCK) && (used_count_o <= USED_MAX))
    else $error("result status or used count out of range");

  // A failed request grants nothing.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> granted_block_o == '0)
    else $error("nonzero grant on a failed request");

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (.*);
